@@ rtl/core/hamming_dedup_top_k_selector_assert.svh @@
// Assertion macros shared by the selector RTL.
`ifndef HAMMING_DEDUP_TOP_K_SELECTOR_ASSERT_SVH
`define HAMMING_DEDUP_TOP_K_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HDTK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hdtk: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HDTK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hdtk: next-cycle check failed");

`endif

@@ rtl/core/hdtk_pkg.sv @@
// Shared types, constants and popcount function of the Hamming top-K selector.
package hdtk_pkg;

  localparam int unsigned CODE_W = 64;
  localparam int unsigned POS_W  = 14;
  localparam int unsigned DIST_W = 9;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned TOP_W  = 7;
  localparam int unsigned PC_W   = 7;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CAND   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [TOP_W-1:0] TOP_RESET = 7'd64;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [POS_W-1:0]  pos;
  } best_entry_t;

  // Bit count of one 64-bit word, reduced through byte-wide partial sums.
  function automatic logic [PC_W-1:0] pop64(input logic [CODE_W-1:0] v);
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    logic [CODE_W-1:0] c;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    c = c + (c >> 8);
    c = c + (c >> 16);
    c = c + (c >> 32);
    return c[PC_W-1:0];
  endfunction

endpackage

@@ rtl/core/hdtk_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
module hdtk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/hamming_dedup_top_k_selector.sv @@
// Top level of the Hamming-distance top-K selector with per-query dedup.
//
// Input channel (valid/ready) carries one request per item: start loads the
// 256-bit query code and opens a query, candidate offers a position and code,
// finish emits the best entries. Results leave on the output channel, one per
// cycle at most, with is_last on the final one; opcode 3 is ignored.
// Handling of each request:
//   start      loads the query; on generation wrap the tag sweep follows.
//   candidate  dropped if its position is out of range or already seen; else
//              it goes into the list by a sorted insert that shifts the list
//              entries behind it (one RAM step per cycle).
//   finish     emits each result by one best-list RAM read, waiting while
//              the receiver is not ready.
// The seen-tag RAM is read then written back in ST_CHK, so the next
// request always sees the updated tag.
// After reset the block sweeps the seen-tag RAM to zero and holds
// in_ready_o low; configuration writes are taken meanwhile.
// A stalled receiver holds the output register; the block keeps taking
// requests until it needs that register for the next result.
module hamming_dedup_top_k_selector #(
  parameter int unsigned DOC_COUNT = 16384,
  parameter int unsigned K_MAX     = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [hdtk_pkg::CODE_W-1:0] code_word_0_i,
  input  logic [hdtk_pkg::CODE_W-1:0] code_word_1_i,
  input  logic [hdtk_pkg::CODE_W-1:0] code_word_2_i,
  input  logic [hdtk_pkg::CODE_W-1:0] code_word_3_i,
  input  logic [hdtk_pkg::POS_W-1:0]  candidate_position_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hdtk_pkg::POS_W-1:0]  result_position_o,
  output logic [hdtk_pkg::DIST_W-1:0] result_distance_o,
  output logic                        is_last_o
);

  `include "hamming_dedup_top_k_selector_assert.svh"

  localparam int unsigned SEEN_AW = $clog2(DOC_COUNT);
  localparam int unsigned BEST_AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int unsigned CNT_W   = $clog2(K_MAX + 1);
  localparam int unsigned EXT_W   =
    ((SEEN_AW > hdtk_pkg::POS_W) ? SEEN_AW : hdtk_pkg::POS_W) + 1;
  localparam int unsigned ENTRY_W = $bits(hdtk_pkg::best_entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK,
    ST_INS_ISSUE,
    ST_INS_CMP,
    ST_INS_FIN,
    ST_EMIT_RD,
    ST_EMIT_WT
  } state_e;

  state_e state_q;

  logic [hdtk_pkg::TOP_W-1:0]  top_count_q;
  logic [hdtk_pkg::CODE_W-1:0] query_q [4];
  logic [hdtk_pkg::GEN_W-1:0]  gen_q;
  logic [CNT_W-1:0]            best_count_q;
  logic [SEEN_AW-1:0]          clr_addr_q;
  logic [SEEN_AW-1:0]          cand_addr_q;
  logic [hdtk_pkg::POS_W-1:0]  cand_pos_q;
  logic [hdtk_pkg::PC_W-1:0]   pc_q [4];
  logic [hdtk_pkg::DIST_W-1:0] dist_q;
  logic [CNT_W-1:0]            ins_j_q;
  logic [CNT_W-1:0]            emit_idx_q;
  logic [CNT_W-1:0]            emit_n_q;

  logic                        out_valid_q;
  logic [hdtk_pkg::POS_W-1:0]  out_pos_q;
  logic [hdtk_pkg::DIST_W-1:0] out_dist_q;
  logic                        out_last_q;

  // ---------------------------------------------------------------- config
  logic cfg_we;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, top_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= hdtk_pkg::TOP_RESET;
    end else if (cfg_we) begin
      top_count_q <= pwdata[hdtk_pkg::TOP_W-1:0];
    end
  end

  // ---------------------------------------------------------------- decode
  logic                  in_fire;
  logic [EXT_W-1:0]      pos_ext;
  logic                  pos_in_range;
  logic                  cand_go;
  logic [CNT_W-1:0]      limit;
  logic [CNT_W-1:0]      emit_n;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign pos_ext      = EXT_W'(candidate_position_i);
  assign pos_in_range = pos_ext < EXT_W'(DOC_COUNT);
  assign cand_go      = in_fire & (opcode_i == hdtk_pkg::OP_CAND) & pos_in_range;

  assign limit  = (top_count_q > hdtk_pkg::TOP_W'(K_MAX)) ? CNT_W'(K_MAX)
                                                            : CNT_W'(top_count_q);
  assign emit_n = (limit < best_count_q) ? limit : best_count_q;

  // ---------------------------------------------------------------- memories
  logic                       seen_we;
  logic [SEEN_AW-1:0]         seen_waddr;
  logic [hdtk_pkg::GEN_W-1:0] seen_wdata;
  logic [hdtk_pkg::GEN_W-1:0] seen_rdata;
  logic                       seen_hit;

  logic                       best_we;
  logic [BEST_AW-1:0]         best_waddr;
  hdtk_pkg::best_entry_t      best_wdata;
  logic [BEST_AW-1:0]         best_raddr;
  logic [ENTRY_W-1:0]         best_rdata_raw;
  hdtk_pkg::best_entry_t      best_rdata;
  hdtk_pkg::best_entry_t      new_entry;
  logic                       new_before;
  logic [CNT_W-1:0]           j_m1;
  logic [CNT_W-1:0]           j_m2;

  assign seen_hit   = (seen_rdata == gen_q);
  assign best_rdata = hdtk_pkg::best_entry_t'(best_rdata_raw);
  assign new_entry  = '{distance: dist_q, pos: cand_pos_q};
  assign new_before = (dist_q == best_rdata.distance) ? (cand_pos_q < best_rdata.pos)
                                                      : (dist_q < best_rdata.distance);
  assign j_m1 = ins_j_q - CNT_W'(1);
  assign j_m2 = ins_j_q - CNT_W'(2);

  always_comb begin
    seen_we    = 1'b0;
    seen_waddr = cand_addr_q;
    seen_wdata = gen_q;
    best_we    = 1'b0;
    best_waddr = '0;
    best_wdata = new_entry;
    best_raddr = emit_idx_q[BEST_AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_addr_q;
        seen_wdata = '0;
      end
      ST_CHK: begin
        seen_we = ~seen_hit;
      end
      ST_INS_ISSUE: begin
        if (ins_j_q == '0) begin
          best_we = 1'b1;
        end else begin
          best_raddr = j_m1[BEST_AW-1:0];
        end
      end
      ST_INS_CMP: begin
        // shift the older entry up, or drop the new one into the gap
        best_waddr = ins_j_q[BEST_AW-1:0];
        best_raddr = j_m2[BEST_AW-1:0];
        if (ins_j_q != CNT_W'(K_MAX)) begin
          best_we = 1'b1;
        end
        if (new_before) begin
          best_wdata = best_rdata;
        end
      end
      ST_INS_FIN: begin
        best_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  hdtk_ram #(
    .WIDTH (hdtk_pkg::GEN_W),
    .DEPTH (DOC_COUNT)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (seen_waddr),
    .wdata_i (seen_wdata),
    .raddr_i (pos_ext[SEEN_AW-1:0]),
    .rdata_o (seen_rdata)
  );

  hdtk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (K_MAX)
  ) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .raddr_i (best_raddr),
    .rdata_o (best_rdata_raw)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      gen_q        <= '0;
      best_count_q <= '0;
      clr_addr_q   <= '0;
      ins_j_q      <= '0;
      emit_idx_q   <= '0;
      emit_n_q     <= '0;
      out_valid_q  <= 1'b0;
      for (int w = 0; w < 4; w++) begin
        query_q[w] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + SEEN_AW'(1);
          if (clr_addr_q == SEEN_AW'(DOC_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            case (opcode_i)
              hdtk_pkg::OP_START: begin
                query_q[0]   <= code_word_0_i;
                query_q[1]   <= code_word_1_i;
                query_q[2]   <= code_word_2_i;
                query_q[3]   <= code_word_3_i;
                best_count_q <= '0;
                if (gen_q == '1) begin
                  // wrap: sweep all tags back to zero
                  gen_q      <= hdtk_pkg::GEN_W'(1);
                  clr_addr_q <= '0;
                  state_q    <= ST_CLEAR;
                end else begin
                  gen_q <= gen_q + hdtk_pkg::GEN_W'(1);
                end
              end
              hdtk_pkg::OP_CAND: begin
                if (pos_in_range) begin
                  state_q <= ST_CHK;
                end
              end
              hdtk_pkg::OP_FINISH: begin
                emit_idx_q <= '0;
                emit_n_q   <= emit_n;
                if (emit_n != '0) begin
                  state_q <= ST_EMIT_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CHK: begin
          if (seen_hit) begin
            state_q <= ST_IDLE;
          end else begin
            ins_j_q <= best_count_q;
            state_q <= ST_INS_ISSUE;
          end
        end
        ST_INS_ISSUE: begin
          if (ins_j_q == '0) begin
            best_count_q <= best_count_q + CNT_W'(1);
            state_q      <= ST_IDLE;
          end else begin
            state_q <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (new_before) begin
            ins_j_q <= j_m1;
            if (ins_j_q == CNT_W'(1)) begin
              state_q <= ST_INS_FIN;
            end
          end else begin
            if (best_count_q != CNT_W'(K_MAX)) begin
              best_count_q <= best_count_q + CNT_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        ST_INS_FIN: begin
          if (best_count_q != CNT_W'(K_MAX)) begin
            best_count_q <= best_count_q + CNT_W'(1);
          end
          state_q <= ST_IDLE;
        end
        ST_EMIT_RD: begin
          // hold the read until the output register is free
          if (!out_valid_q) begin
            state_q <= ST_EMIT_WT;
          end
        end
        ST_EMIT_WT: begin
          out_valid_q <= 1'b1;
          if (emit_idx_q == emit_n_q - CNT_W'(1)) begin
            state_q <= ST_IDLE;
          end else begin
            emit_idx_q <= emit_idx_q + CNT_W'(1);
            state_q    <= ST_EMIT_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (cand_go) begin
      cand_addr_q <= pos_ext[SEEN_AW-1:0];
      cand_pos_q  <= candidate_position_i;
      pc_q[0]     <= hdtk_pkg::pop64(query_q[0] ^ code_word_0_i);
      pc_q[1]     <= hdtk_pkg::pop64(query_q[1] ^ code_word_1_i);
      pc_q[2]     <= hdtk_pkg::pop64(query_q[2] ^ code_word_2_i);
      pc_q[3]     <= hdtk_pkg::pop64(query_q[3] ^ code_word_3_i);
    end
    if (state_q == ST_CHK) begin
      dist_q <= hdtk_pkg::DIST_W'(pc_q[0]) + hdtk_pkg::DIST_W'(pc_q[1])
              + hdtk_pkg::DIST_W'(pc_q[2]) + hdtk_pkg::DIST_W'(pc_q[3]);
    end
    if (state_q == ST_EMIT_WT) begin
      out_pos_q  <= best_rdata.pos;
      out_dist_q <= best_rdata.distance;
      out_last_q <= (emit_idx_q == emit_n_q - CNT_W'(1));
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_position_o = out_pos_q;
  assign result_distance_o = out_dist_q;
  assign is_last_o         = out_last_q;

  // ---------------------------------------------------------------- checks
  `HDTK_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, best_count_q <= CNT_W'(K_MAX))
  `HDTK_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni, state_q == ST_EMIT_WT, !out_valid_q)
  `HDTK_ASSERT_NXT(a_cand_to_chk, clk_i, rst_ni, cand_go, state_q == ST_CHK)
  `HDTK_ASSERT_IMP(a_ins_index, clk_i, rst_ni, state_q == ST_INS_CMP, ins_j_q != '0)
  `HDTK_ASSERT_IMP(a_emit_index, clk_i, rst_ni, state_q == ST_EMIT_RD, emit_idx_q < emit_n_q)

endmodule
